@@ src/gsg_pkg.sv @@
// Shared types and constants for the gradient span generator.
// No dependencies; every other file but the two channel interfaces imports this package.
package gsg_pkg;

	localparam int LAYER_WORDS = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int CFG_IDX_W = 2;

	// input item modes
	typedef enum logic [1:0] {
		MODE_LUT   = 2'd0,
		MODE_LAYER = 2'd1,
		MODE_SPAN  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALL_FLAT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FLAT_COLOR  = 2'd2;

	// layer control word codes
	localparam logic [1:0] KIND_LINEAR    = 2'd1;
	localparam logic [1:0] KIND_RADIAL    = 2'd2;
	localparam logic [1:0] SPREAD_REPEAT  = 2'd1;
	localparam logic [1:0] SPREAD_REFLECT = 2'd2;

	typedef enum logic [1:0] {OP_LUT, OP_LAYER, OP_SPAN} op_t;

	typedef struct packed {
		op_t                op;
		logic [9:0]         addr;
		logic [63:0]        data;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [7:0]  dx;
		logic signed [7:0]  dy;
		logic [6:0]         len;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  layer_count;
		logic        all_flat;
		logic [63:0] flat_color;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_FETCH, ST_MUL, ST_INIT1, ST_INIT2, ST_PIX, ST_SQ1, ST_SQ2,
		ST_SQRT, ST_RIDX, ST_LK1, ST_LK2, ST_LK3, ST_LK4, ST_OUT_RD, ST_OUT_LD
	} state_t;

	typedef enum logic [1:0] {SRC_LUT, SRC_PAD, SRC_FLAT} src_t;

	typedef enum logic [1:0] {OSRC_RAW, OSRC_MIX, OSRC_FLAT, OSRC_ZERO} osrc_t;

endpackage

@@ src/gsg_in_if.sv @@
// Input channel of the gradient span generator: valid/ready plus item fields.
// No dependencies.
interface gsg_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [9:0]         addr;
	logic [63:0]        data;
	logic signed [15:0] pos_x;
	logic signed [15:0] pos_y;
	logic signed [7:0]  step_x;
	logic signed [7:0]  step_y;
	logic [6:0]         span_length;

	modport source(output valid, mode, addr, data, pos_x, pos_y, step_x, step_y,
		span_length, input ready);
	modport sink(input valid, mode, addr, data, pos_x, pos_y, step_x, step_y,
		span_length, output ready);
endinterface

@@ src/gsg_out_if.sv @@
// Output channel of the gradient span generator: one RGBA pixel per beat.
// No dependencies.
interface gsg_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] red;
	logic signed [15:0] green;
	logic signed [15:0] blue;
	logic signed [15:0] alpha;
	logic               last;

	modport source(output valid, red, green, blue, alpha, last, input ready);
	modport sink(input valid, red, green, blue, alpha, last, output ready);
endinterface

@@ src/gsg_front.sv @@
// Front end: accepts input beats, drops empty ones, builds queue commands.
// Depends on gsg_pkg and gsg_in_if.
module gsg_front #(
	parameter int MAX_SPAN = 64
) (
	gsg_in_if.sink          in_ch,
	output logic            push_valid,
	input  logic            push_ready,
	output gsg_pkg::cmd_t   push_cmd
);
	import gsg_pkg::*;

	logic keep;

	// drop the unused mode and empty spans
	always_comb begin
		keep = 1'b1;
		if (in_ch.mode == MODE_NONE) keep = 1'b0;
		if (in_ch.mode == MODE_SPAN && in_ch.span_length == 7'd0) keep = 1'b0;
	end

	assign in_ch.ready = push_ready;
	assign push_valid  = in_ch.valid && keep;

	// classify and clamp the span length
	always_comb begin
		case (in_ch.mode)
			MODE_LUT:   push_cmd.op = OP_LUT;
			MODE_LAYER: push_cmd.op = OP_LAYER;
			default:    push_cmd.op = OP_SPAN;
		endcase
		push_cmd.addr = in_ch.addr;
		push_cmd.data = in_ch.data;
		push_cmd.x    = in_ch.pos_x;
		push_cmd.y    = in_ch.pos_y;
		push_cmd.dx   = in_ch.step_x;
		push_cmd.dy   = in_ch.step_y;
		push_cmd.len  = (int'(in_ch.span_length) > MAX_SPAN) ? 7'(MAX_SPAN)
			: in_ch.span_length;
	end
endmodule

@@ src/gsg_queue.sv @@
// Short command queue between the front end and the span engine.
// Depends on gsg_pkg.
module gsg_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  gsg_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	output gsg_pkg::cmd_t pop_cmd,
	input  logic          pop
);
	import gsg_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	cmd_t            slot_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (int'(count_q) < QUEUE_DEPTH);
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (int'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (int'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	// hold command payloads
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_cmd;
	end
endmodule

@@ src/gsg_engine.sv @@
// Span engine: table stores, layer setup sequencer, per-pixel lookup and
// mixing, and the output register. Depends on gsg_pkg and gsg_out_if.
module gsg_engine #(
	parameter int MAX_LAYERS = 4,
	parameter int LUT_DEPTH  = 1024,
	parameter int MAX_SPAN   = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  gsg_pkg::cfg_t cfg,
	input  logic          cmd_valid,
	input  gsg_pkg::cmd_t cmd,
	output logic          cmd_pop,
	gsg_out_if.source     out_ch
);
	import gsg_pkg::*;

	localparam int LUT_AW      = (LUT_DEPTH > 1) ? $clog2(LUT_DEPTH) : 1;
	localparam int LAYER_DEPTH = MAX_LAYERS * LAYER_WORDS;
	localparam int LAY_AW      = $clog2(LAYER_DEPTH);
	localparam int SPAN_AW     = (MAX_SPAN > 1) ? $clog2(MAX_SPAN) : 1;
	localparam int LCW         = $clog2(MAX_LAYERS + 1);
	localparam int ACCW        = 33 + $clog2(MAX_LAYERS);
	localparam int RK          = 30;
	localparam int RECIP       = (1 << RK) / LUT_DEPTH;
	localparam int RW          = $clog2(RECIP + 1);
	localparam int QW          = 17 + RW;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		else if (v < -64'sd2147483648) return 32'sh80000000;
		else return v[31:0];
	endfunction

	// stores
	logic [63:0]          lut_mem [LUT_DEPTH];
	logic [63:0]          lut_rd_q;
	logic [63:0]          lay_mem [LAYER_DEPTH];
	logic [63:0]          lay_rd_q;
	logic [4*ACCW-1:0]    acc_mem [MAX_SPAN];
	logic [4*ACCW-1:0]    acc_rd_q;

	// control
	state_t               state_q, state_d;
	logic [2:0]           word_q;
	logic [1:0]           mprod_q;
	logic [1:0]           part_q;
	logic [6:0]           pix_q;
	logic [6:0]           len_q;
	logic [4:0]           sq_cnt_q;
	logic [LCW-1:0]       layer_q;
	logic [LCW-1:0]       nl_q;
	logic [LCW-1:0]       nl_cfg;
	osrc_t                osrc_q;
	src_t                 src_q;
	logic                 out_valid_q;
	logic                 out_last_q;
	logic [63:0]          out_color_q;

	// payload
	logic signed [15:0]   x_q, y_q;
	logic signed [7:0]    dx_q, dy_q;
	logic [63:0]          ctrl_q, flat_w_q, pad_w_q, w3_q, w4_q, w5_q;
	logic [63:0]          p_q [4];
	logic [63:0]          t2_q, sv_q, pos_q, step_q, rem_q, res_q;
	logic signed [31:0]   u_q, v_q;
	logic signed [40:0]   du_q, dv_q;
	logic signed [48:0]   idx_q;
	logic [16:0]          sum_q;
	logic [16:0]          quo_q;

	// decoded fields and helpers
	logic [1:0]           kind, spread;
	logic [3:0]           bits;
	logic [11:0]          ofs;
	logic [15:0]          wt;
	logic                 is_lin, is_rad, last_pix, last_layer, load_out;
	logic                 lut_we, lay_we, lut_re, lay_re, acc_re, acc_we;
	logic [LUT_AW-1:0]    lut_raddr;
	logic [LAY_AW-1:0]    lay_raddr;
	logic [63:0]          op_a, op_b;
	logic [31:0]          ma, mb, abs_u, abs_v;
	logic [63:0]          mul_out;
	logic [63:0]          px, py, irx, iry;
	logic [4:0]           sh1, sh2;
	logic [63:0]          half, mag, rnd;
	logic [5:0]           bsh;
	logic [63:0]          bitv, trial;
	logic [47:0]          tshift;
	logic [16:0]          n, e;
	logic [17:0]          n2, refl;
	logic                 pad_hit;
	logic [QW-1:0]        qprod;
	logic [16:0]          rr0, rr;
	logic [63:0]          color;
	logic [4*ACCW-1:0]    acc_wd;
	logic [63:0]          out_word;

	assign kind       = ctrl_q[1:0];
	assign spread     = ctrl_q[3:2];
	assign bits       = ctrl_q[7:4];
	assign ofs        = ctrl_q[19:8];
	assign wt         = ctrl_q[35:20];
	assign is_lin     = (kind == KIND_LINEAR);
	assign is_rad     = (kind == KIND_RADIAL);
	assign last_pix   = (pix_q == len_q - 7'd1);
	assign last_layer = ((layer_q + 1'b1) == nl_q);
	assign nl_cfg     = (int'(cfg.layer_count) > MAX_LAYERS) ? LCW'(MAX_LAYERS)
		: LCW'(cfg.layer_count);
	assign load_out   = (state_q == ST_OUT_LD) && (!out_valid_q || out_ch.ready);

	// next state
	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.op == OP_SPAN) begin
						if (cfg.all_flat || nl_cfg == '0) state_d = ST_OUT_LD;
						else state_d = ST_FETCH;
					end
				end
			end
			ST_FETCH: if (word_q == 3'd6) state_d = (is_lin || is_rad) ? ST_MUL : ST_PIX;
			ST_MUL:   if (part_q == 2'd2 && mprod_q == 2'd3) state_d = ST_INIT1;
			ST_INIT1: state_d = is_lin ? ST_INIT2 : ST_PIX;
			ST_INIT2: state_d = ST_PIX;
			ST_PIX: begin
				if (is_lin) state_d = ST_LK1;
				else if (is_rad) state_d = ST_SQ1;
				else state_d = ST_LK3;
			end
			ST_SQ1:   state_d = ST_SQ2;
			ST_SQ2:   state_d = ST_SQRT;
			ST_SQRT:  if (sq_cnt_q == 5'd31) state_d = ST_RIDX;
			ST_RIDX:  state_d = ST_LK1;
			ST_LK1:   state_d = ST_LK2;
			ST_LK2:   state_d = ST_LK3;
			ST_LK3:   state_d = ST_LK4;
			ST_LK4: begin
				if (!last_pix) state_d = ST_PIX;
				else if (last_layer) state_d = ST_OUT_RD;
				else state_d = ST_FETCH;
			end
			ST_OUT_RD: state_d = ST_OUT_LD;
			ST_OUT_LD: begin
				if (load_out) begin
					if (last_pix) state_d = ST_IDLE;
					else if (osrc_q == OSRC_FLAT || osrc_q == OSRC_ZERO) state_d = ST_OUT_LD;
					else state_d = ST_OUT_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// sequencing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q   <= '0;
			mprod_q  <= '0;
			part_q   <= '0;
			pix_q    <= '0;
			len_q    <= '0;
			sq_cnt_q <= '0;
			layer_q  <= '0;
			nl_q     <= '0;
			osrc_q   <= OSRC_ZERO;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid && cmd.op == OP_SPAN) begin
						len_q   <= cmd.len;
						nl_q    <= nl_cfg;
						layer_q <= '0;
						word_q  <= '0;
						pix_q   <= '0;
						if (cfg.all_flat) osrc_q <= OSRC_FLAT;
						else if (nl_cfg == '0) osrc_q <= OSRC_ZERO;
						else if (nl_cfg == LCW'(1)) osrc_q <= OSRC_RAW;
						else osrc_q <= OSRC_MIX;
					end
				end
				ST_FETCH: begin
					word_q  <= word_q + 3'd1;
					mprod_q <= '0;
					part_q  <= '0;
					pix_q   <= '0;
				end
				ST_MUL: begin
					if (part_q == 2'd2) begin
						part_q  <= '0;
						mprod_q <= mprod_q + 2'd1;
					end else begin
						part_q <= part_q + 2'd1;
					end
				end
				ST_SQ2:  sq_cnt_q <= '0;
				ST_SQRT: sq_cnt_q <= sq_cnt_q + 5'd1;
				ST_LK4: begin
					if (last_pix) begin
						pix_q <= '0;
						if (!last_layer) begin
							layer_q <= layer_q + 1'b1;
							word_q  <= '0;
						end
					end else begin
						pix_q <= pix_q + 7'd1;
					end
				end
				ST_OUT_LD: if (load_out) pix_q <= pix_q + 7'd1;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (load_out) out_valid_q <= 1'b1;
		else if (out_ch.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_color_q <= out_word;
			out_last_q  <= last_pix;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.red   = out_color_q[15:0];
	assign out_ch.green = out_color_q[31:16];
	assign out_ch.blue  = out_color_q[47:32];
	assign out_ch.alpha = out_color_q[63:48];
	assign out_ch.last  = out_last_q;

	// store ports
	assign lut_we    = (state_q == ST_IDLE) && cmd_valid && cmd.op == OP_LUT
		&& (int'(cmd.addr) < LUT_DEPTH);
	assign lay_we    = (state_q == ST_IDLE) && cmd_valid && cmd.op == OP_LAYER
		&& (int'(cmd.addr) < LAYER_DEPTH);
	assign lut_re    = (state_q == ST_LK3);
	assign lay_re    = (state_q == ST_FETCH);
	assign acc_re    = (state_q == ST_LK3) || (state_q == ST_OUT_RD);
	assign acc_we    = (state_q == ST_LK4);
	assign lut_raddr = LUT_AW'(rr);
	assign lay_raddr = LAY_AW'(int'(layer_q) * LAYER_WORDS + int'(word_q));

	always_ff @(posedge clk) begin
		if (lut_we) lut_mem[LUT_AW'(cmd.addr)] <= cmd.data;
		if (lut_re) lut_rd_q <= lut_mem[lut_raddr];
	end

	always_ff @(posedge clk) begin
		if (lay_we) lay_mem[LAY_AW'(cmd.addr)] <= cmd.data;
		if (lay_re) lay_rd_q <= lay_mem[lay_raddr];
	end

	always_ff @(posedge clk) begin
		if (acc_we) acc_mem[pix_q[SPAN_AW-1:0]] <= acc_wd;
		if (acc_re) acc_rd_q <= acc_mem[pix_q[SPAN_AW-1:0]];
	end

	// setup multiplier operands: low 64 bits of a product in three 32x32 parts
	always_comb begin
		px  = {{32{x_q[15]}}, x_q, 16'h8000} - {{32{w3_q[31]}}, w3_q[31:0]};
		py  = {{32{y_q[15]}}, y_q, 16'h8000} - {{32{w3_q[63]}}, w3_q[63:32]};
		irx = {{32{w4_q[31]}}, w4_q[31:0]};
		iry = {{32{w4_q[63]}}, w4_q[63:32]};
		case (mprod_q)
			2'd0: begin
				op_a = is_lin ? w3_q : px;
				op_b = is_lin ? {{47{x_q[15]}}, x_q, 1'b1} : irx;
			end
			2'd1: begin
				op_a = is_lin ? w4_q : py;
				op_b = is_lin ? {{47{y_q[15]}}, y_q, 1'b1} : iry;
			end
			2'd2: begin
				op_a = {{56{dx_q[7]}}, dx_q};
				op_b = is_lin ? w3_q : irx;
			end
			default: begin
				op_a = {{56{dy_q[7]}}, dy_q};
				op_b = is_lin ? w4_q : iry;
			end
		endcase
		abs_u = u_q[31] ? (~u_q + 32'd1) : u_q;
		abs_v = v_q[31] ? (~v_q + 32'd1) : v_q;
		case (state_q)
			ST_SQ1: begin
				ma = abs_u;
				mb = abs_u;
			end
			ST_SQ2: begin
				ma = abs_v;
				mb = abs_v;
			end
			default: begin
				ma = (part_q == 2'd2) ? op_a[63:32] : op_a[31:0];
				mb = (part_q == 2'd1) ? op_b[63:32] : op_b[31:0];
			end
		endcase
		mul_out = {32'd0, ma} * {32'd0, mb};
	end

	// linear start and step, square root step, table index math
	always_comb begin
		sh1    = 5'd25 - {1'b0, bits};
		sh2    = 5'd24 - {1'b0, bits};
		half   = 64'd1 << (sh2 - 5'd1);
		mag    = sv_q[63] ? (~sv_q + 64'd1) : sv_q;
		rnd    = (mag + half) >> sh2;
		bsh    = 6'd62 - {sq_cnt_q, 1'b0};
		bitv   = 64'd1 << bsh;
		trial  = res_q + bitv;
		tshift = {15'd0, res_q[32:0]} << bits;
		n      = 17'd1 << bits;
		n2     = {n, 1'b0};
		refl   = {1'b0, idx_q[16:0]} & (n2 - 18'd1);
		pad_hit = 1'b0;
		case (spread)
			SPREAD_REPEAT:  e = idx_q[16:0] & (n - 17'd1);
			SPREAD_REFLECT: e = (refl >= {1'b0, n}) ? 17'(n2 - 18'd1 - refl) : refl[16:0];
			default: begin
				pad_hit = idx_q[48];
				e = (idx_q > 49'(n)) ? n : idx_q[16:0];
			end
		endcase
		qprod = QW'(sum_q) * QW'(RECIP);
		rr0   = sum_q - 17'(quo_q * 17'(LUT_DEPTH));
		rr    = (rr0 >= 17'(LUT_DEPTH)) ? rr0 - 17'(LUT_DEPTH) : rr0;
	end

	// accumulate one pixel of one layer
	always_comb begin
		logic signed [15:0]     ch;
		logic signed [32:0]     prod;
		logic signed [ACCW-1:0] prev;
		logic signed [ACCW-1:0] term;
		case (src_q)
			SRC_FLAT: color = flat_w_q;
			SRC_PAD:  color = pad_w_q;
			default:  color = lut_rd_q;
		endcase
		for (int k = 0; k < 4; k++) begin
			ch   = color[16*k +: 16];
			prod = ch * $signed({1'b0, wt});
			prev = (layer_q == '0) ? '0 : $signed(acc_rd_q[ACCW*k +: ACCW]);
			term = (osrc_q == OSRC_RAW) ? ACCW'(ch) : ACCW'(prod);
			acc_wd[ACCW*k +: ACCW] = prev + term;
		end
	end

	// final pixel colour
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			case (osrc_q)
				OSRC_FLAT: out_word[16*k +: 16] = cfg.flat_color[16*k +: 16];
				OSRC_RAW:  out_word[16*k +: 16] = acc_rd_q[ACCW*k +: 16];
				OSRC_MIX:  out_word[16*k +: 16] = acc_rd_q[ACCW*k + 12 +: 16];
				default:   out_word[16*k +: 16] = 16'd0;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && cmd.op == OP_SPAN) begin
					x_q  <= cmd.x;
					y_q  <= cmd.y;
					dx_q <= cmd.dx;
					dy_q <= cmd.dy;
				end
			end
			ST_FETCH: begin
				case (word_q)
					3'd1: ctrl_q   <= lay_rd_q;
					3'd2: flat_w_q <= lay_rd_q;
					3'd3: pad_w_q  <= lay_rd_q;
					3'd4: w3_q     <= lay_rd_q;
					3'd5: w4_q     <= lay_rd_q;
					3'd6: w5_q     <= lay_rd_q;
					default: ;
				endcase
			end
			ST_MUL: begin
				if (part_q == 2'd0) p_q[mprod_q] <= mul_out;
				else p_q[mprod_q] <= p_q[mprod_q] + {mul_out[31:0], 32'd0};
			end
			ST_INIT1: begin
				t2_q <= p_q[0] + p_q[1] + {w5_q[62:0], 1'b0};
				sv_q <= p_q[2] + p_q[3];
				u_q  <= sat32($signed(p_q[0]) >>> 16);
				v_q  <= sat32($signed(p_q[1]) >>> 16);
				du_q <= p_q[2][40:0];
				dv_q <= p_q[3][40:0];
			end
			ST_INIT2: begin
				pos_q  <= $signed(t2_q) >>> sh1;
				step_q <= sv_q[63] ? (~rnd + 64'd1) : rnd;
			end
			ST_PIX: begin
				idx_q <= {pos_q[63], pos_q[63:16]};
				if (is_lin) pos_q <= pos_q + step_q;
				src_q <= SRC_FLAT;
			end
			ST_SQ1: rem_q <= mul_out;
			ST_SQ2: begin
				rem_q <= rem_q + mul_out;
				res_q <= '0;
				u_q   <= sat32(64'(u_q) + 64'(du_q));
				v_q   <= sat32(64'(v_q) + 64'(dv_q));
			end
			ST_SQRT: begin
				if (rem_q >= trial) begin
					rem_q <= rem_q - trial;
					res_q <= (res_q >> 1) + bitv;
				end else begin
					res_q <= res_q >> 1;
				end
			end
			// the root of a 64-bit sum stays far below the 1e9 cap
			ST_RIDX: idx_q <= 49'(tshift[47:16]);
			ST_LK1: begin
				sum_q <= 17'(ofs) + e;
				src_q <= pad_hit ? SRC_PAD : SRC_LUT;
			end
			ST_LK2: quo_q <= 17'(qprod >> RK);
			default: ;
		endcase
	end
endmodule

@@ src/gradient_span_generator_core.sv @@
// Gradient span generator top: configuration registers, front end, queue, engine.
// A flat span gives one pixel per cycle while the receiver is ready. Each layer
// fetches its words; linear and radial kinds then form four products in three
// 32x32 parts and init. Pixels then pass the table lookup, radial ones after a
// bit-serial root, and layered output is read back per pixel from the accumulator.
// Reset clears control and queue state; table stores are undefined until written.
module gradient_span_generator_core #(
	parameter int MAX_LAYERS = 4,
	parameter int LUT_DEPTH  = 1024,
	parameter int MAX_SPAN   = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [gsg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [63:0]                    cfg_data,
	gsg_in_if.sink                         in_ch,
	gsg_out_if.source                      out_ch
);
	import gsg_pkg::*;

	cfg_t cfg_q;
	logic q_push, q_ready, q_valid, q_pop;
	cmd_t push_cmd, pop_cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.layer_count <= 3'd0;
			cfg_q.all_flat    <= 1'b1;
			cfg_q.flat_color  <= 64'd0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_LAYER_COUNT: cfg_q.layer_count <= cfg_data[2:0];
				CFG_ALL_FLAT:    cfg_q.all_flat    <= cfg_data[0];
				CFG_FLAT_COLOR:  cfg_q.flat_color  <= cfg_data;
				default: ;
			endcase
		end
	end

	gsg_front #(.MAX_SPAN(MAX_SPAN)) u_front (
		.in_ch      (in_ch),
		.push_valid (q_push),
		.push_ready (q_ready),
		.push_cmd   (push_cmd)
	);

	gsg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push),
		.push_ready (q_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (q_valid),
		.pop_cmd    (pop_cmd),
		.pop        (q_pop)
	);

	gsg_engine #(
		.MAX_LAYERS (MAX_LAYERS),
		.LUT_DEPTH  (LUT_DEPTH),
		.MAX_SPAN   (MAX_SPAN)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (q_valid),
		.cmd       (pop_cmd),
		.cmd_pop   (q_pop),
		.out_ch    (out_ch)
	);

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("engine popped an empty queue");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && !q_ready |-> !in_ch.ready) else $error("push into full queue");

	a_drop_unused_mode: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.mode == MODE_NONE |-> !q_push)
		else $error("unused mode reached the queue");
endmodule

@@ dv/testbench.sv @@
// Self-checking bench for gradient_span_generator_core: table loads, flat, linear, radial
// and mixed spans, checked pixel by pixel against an in-bench predictor.
// Depends on gsg_pkg, gsg_in_if, gsg_out_if and the core.
`timescale 1ns / 100ps

module testbench;
	import gsg_pkg::*;

	localparam int NLAYER = 4;
	localparam int LUT_N = 1024;
	localparam int SPAN_MAX = 64;
	// written table window: entries 1012..1023 then 0..11
	localparam int WIN_BASE = 1012;
	localparam int WIN_LEN = 24;

	typedef struct {
		logic [63:0] color;
		logic        last;
	} pixel_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wr_en = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	gsg_in_if in_ch();
	gsg_out_if out_ch();

	gradient_span_generator_core u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	always #2 clk = ~clk;

	// mirror of the block's stores and registers
	logic [63:0] lut_mirror [LUT_N];
	logic [63:0] layer_mirror [NLAYER*LAYER_WORDS];
	logic [2:0]  layer_count_q = 3'd0;
	logic        all_flat_q = 1'b1;
	logic [63:0] flat_color_q = '0;
	logic [63:0] layer_pix [SPAN_MAX];
	logic [63:0] span_pix [SPAN_MAX];
	longint      mix_acc [SPAN_MAX][4];

	pixel_t pixel_q [$];
	int snd_idle = 0;
	int rcv_idle = 0;
	int hold_left = 0;
	int mismatches = 0;
	int pixels_seen = 0;
	int spans_sent = 0;
	int loads_sent = 0;

	// ---------------- predictor ----------------
	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] slice_read(logic [63:0] ctrl, logic [63:0] pad, longint idx);
		logic [1:0] spread;
		logic [63:0] n;
		logic [63:0] r;
		logic [63:0] e;
		logic [63:0] sum;
		spread = ctrl[3:2];
		n = 64'd1 << ctrl[7:4];
		if (spread == SPREAD_REPEAT) begin
			e = idx & (n - 1);
		end else if (spread == SPREAD_REFLECT) begin
			r = idx & (2*n - 1);
			e = (r >= n) ? 2*n - 1 - r : r;
		end else begin
			if (idx < 0) return pad;
			e = (idx > longint'(n)) ? n : idx;
		end
		sum = {52'd0, ctrl[19:8]} + e;
		return lut_mirror[sum[9:0]];
	endfunction

	// fill layer_pix with the colours of one layer
	function automatic void layer_span(int l, longint x, longint y, longint dx, longint dy,
			int len);
		logic [63:0] ctrl, pad, a, b, c, t2, mag, half;
		int bits, sh;
		longint pos, sv, step, cx, cy, irx, iry, u, v, du, dv;
		longint unsigned t;
		ctrl = layer_mirror[l*LAYER_WORDS];
		pad = layer_mirror[l*LAYER_WORDS+2];
		a = layer_mirror[l*LAYER_WORDS+3];
		b = layer_mirror[l*LAYER_WORDS+4];
		c = layer_mirror[l*LAYER_WORDS+5];
		bits = int'(ctrl[7:4]);
		if (ctrl[1:0] == KIND_LINEAR) begin
			t2 = a * (2*x + 1) + b * (2*y + 1) + 2*c;
			pos = signed'(t2) >>> (25 - bits);
			sv = signed'(a * dx + b * dy);
			sh = 24 - bits;
			half = 64'd1 << (sh - 1);
			if (sv >= 0) begin
				step = (sv + half) >> sh;
			end else begin
				mag = 64'd0 - sv;
				step = -longint'((mag + half) >> sh);
			end
			for (int i = 0; i < len; i++) begin
				layer_pix[i] = slice_read(ctrl, pad, pos >>> 16);
				pos = pos + step;
			end
		end else if (ctrl[1:0] == KIND_RADIAL) begin
			cx = longint'(signed'(a[31:0]));
			cy = longint'(signed'(a[63:32]));
			irx = longint'(signed'(b[31:0]));
			iry = longint'(signed'(b[63:32]));
			u = clamp32(((x*65536 + 32768 - cx) * irx) >>> 16);
			v = clamp32(((y*65536 + 32768 - cy) * iry) >>> 16);
			du = dx * irx;
			dv = dy * iry;
			for (int i = 0; i < len; i++) begin
				t = int_sqrt(u*u + v*v);
				if (t > 64'd1000000000 * 65536) t = 64'd1000000000 * 65536;
				layer_pix[i] = slice_read(ctrl, pad, longint'((t << bits) >> 16));
				u = clamp32(u + du);
				v = clamp32(v + dv);
			end
		end else begin
			for (int i = 0; i < len; i++) layer_pix[i] = layer_mirror[l*LAYER_WORDS+1];
		end
	endfunction

	// apply one accepted item to the mirror and queue its pixels
	function automatic void predict_item(logic [1:0] mode, logic [9:0] addr, logic [63:0] data,
			logic signed [15:0] x, logic signed [15:0] y, logic signed [7:0] dx,
			logic signed [7:0] dy, logic [6:0] len_in);
		int len, nl;
		longint wt;
		pixel_t px;
		if (mode == MODE_LUT) begin
			lut_mirror[addr] = data;
			return;
		end
		if (mode == MODE_LAYER) begin
			if (addr < NLAYER*LAYER_WORDS) layer_mirror[addr] = data;
			return;
		end
		if (mode != MODE_SPAN) return;
		len = (len_in > SPAN_MAX) ? SPAN_MAX : int'(len_in);
		nl = (layer_count_q > NLAYER) ? NLAYER : int'(layer_count_q);
		if (all_flat_q) begin
			for (int i = 0; i < len; i++) span_pix[i] = flat_color_q;
		end else if (nl == 1) begin
			layer_span(0, x, y, dx, dy, len);
			for (int i = 0; i < len; i++) span_pix[i] = layer_pix[i];
		end else begin
			for (int i = 0; i < len; i++)
				for (int k = 0; k < 4; k++) mix_acc[i][k] = 0;
			for (int l = 0; l < nl; l++) begin
				wt = longint'(layer_mirror[l*LAYER_WORDS][35:20]);
				layer_span(l, x, y, dx, dy, len);
				for (int i = 0; i < len; i++)
					for (int k = 0; k < 4; k++)
						mix_acc[i][k] += longint'(signed'(layer_pix[i][16*k +: 16])) * wt;
			end
			for (int i = 0; i < len; i++)
				for (int k = 0; k < 4; k++)
					span_pix[i][16*k +: 16] = 16'(mix_acc[i][k] >>> 12);
		end
		for (int i = 0; i < len; i++) begin
			px.color = span_pix[i];
			px.last = (i == len - 1);
			pixel_q.push_back(px);
		end
	endfunction

	// ---------------- stimulus helpers ----------------
	task automatic send_item(logic [1:0] mode, logic [9:0] addr, logic [63:0] data,
			logic signed [15:0] x, logic signed [15:0] y, logic signed [7:0] dx,
			logic signed [7:0] dy, logic [6:0] len);
		logic hs;
		if ($urandom_range(99) < snd_idle) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= mode;
		in_ch.addr <= addr;
		in_ch.data <= data;
		in_ch.pos_x <= x;
		in_ch.pos_y <= y;
		in_ch.step_x <= dx;
		in_ch.step_y <= dy;
		in_ch.span_length <= len;
		forever begin
			@(negedge clk);
			hs = in_ch.ready;
			@(posedge clk);
			if (hs) break;
		end
		predict_item(mode, addr, data, x, y, dx, dy, len);
		if (mode == MODE_SPAN) spans_sent++;
		else loads_sent++;
	endtask

	task automatic load_lut(logic [9:0] addr, logic [63:0] data);
		send_item(MODE_LUT, addr, data, 16'($urandom), 16'($urandom), 8'($urandom),
			8'($urandom), 7'($urandom));
	endtask

	task automatic load_layer(logic [9:0] addr, logic [63:0] data);
		send_item(MODE_LAYER, addr, data, 16'($urandom), 16'($urandom), 8'($urandom),
			8'($urandom), 7'($urandom));
	endtask

	task automatic span(logic signed [15:0] x, logic signed [15:0] y, logic signed [7:0] dx,
			logic signed [7:0] dy, logic [6:0] len);
		send_item(MODE_SPAN, 10'($urandom), {$urandom, $urandom}, x, y, dx, dy, len);
	endtask

	// drop valid and wait until every pixel is back and the engine has settled
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_LAYER_COUNT) layer_count_q = value[2:0];
		else if (idx == CFG_ALL_FLAT) all_flat_q = value[0];
		else if (idx == CFG_FLAT_COLOR) flat_color_q = value;
	endtask

	// control word whose table slice lies inside the written window
	function automatic logic [63:0] ctrl_word(logic [1:0] kind, logic [1:0] spread);
		logic [63:0] w;
		int bits, ofs;
		bits = $urandom_range(0, 4);
		ofs = (WIN_BASE + $urandom_range(0, WIN_LEN - (1 << bits) - 1)) % LUT_N
			+ LUT_N * $urandom_range(0, 3);
		w = {$urandom, $urandom};
		w[1:0] = kind;
		w[3:2] = spread;
		w[7:4] = 4'(bits);
		w[19:8] = 12'(ofs);
		return w;
	endfunction

	function automatic logic [63:0] coef_word();
		longint a;
		logic [31:0] lo, hi;
		case ($urandom_range(0, 9))
			0: return {$urandom, $urandom};
			1, 2, 3: begin
				a = longint'(int'($urandom)) * (64'sd1 << $urandom_range(0, 9));
				return a;
			end
			default: begin
				lo = $urandom;
				hi = $urandom;
				if ($urandom_range(0, 1)) begin
					lo = int'(lo) >>> $urandom_range(14, 24);
					hi = int'(hi) >>> $urandom_range(14, 24);
				end
				return {hi, lo};
			end
		endcase
	endfunction

	function automatic logic [63:0] layer_word(int idx);
		case (idx % LAYER_WORDS)
			0: return ctrl_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
			3, 4, 5: return coef_word();
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic random_span(int long_pct);
		int len;
		len = ($urandom_range(99) < long_pct) ? $urandom_range(0, 127) : $urandom_range(1, 8);
		span(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 7'(len));
	endtask

	// ---------------- checking ----------------
	function automatic void report(string what, logic [63:0] exp_c, logic exp_l, logic [63:0] act_c,
			logic act_l);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %h last %b, got %h last %b", what, exp_c, exp_l,
				act_c, act_l);
	endfunction

	// receiver: random stall, plus a long hold when asked
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	// compare each beat just before the edge that takes it
	always @(negedge clk) begin
		pixel_t exp_px;
		logic [63:0] got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.alpha, out_ch.blue, out_ch.green, out_ch.red};
			pixels_seen++;
			if (pixel_q.size() == 0) begin
				report("unexpected pixel", '0, 1'b0, got, out_ch.last);
			end else begin
				exp_px = pixel_q.pop_front();
				if (got !== exp_px.color || out_ch.last !== exp_px.last)
					report("pixel", exp_px.color, exp_px.last, got, out_ch.last);
			end
		end
	end

	// ---------------- tests ----------------
	task automatic test_load_tables();
		for (int i = 0; i < WIN_LEN; i++)
			load_lut(10'((WIN_BASE + i) % LUT_N), {$urandom, $urandom});
		for (int i = 0; i < NLAYER*LAYER_WORDS; i++) load_layer(10'(i), layer_word(i));
		// out-of-range layer word writes are dropped
		load_layer(10'h3ff, {$urandom, $urandom});
		load_layer(10'd32, {$urandom, $urandom});
	endtask

	task automatic test_flat_fill();
		span(16'sh7fff, -16'sh8000, 8'sh7f, -8'sh80, 7'd1);
		write_reg(CFG_FLAT_COLOR, 64'h8000_7fff_ffff_0000);
		span(-16'sh8000, 16'sh7fff, -8'sh80, 8'sh7f, 7'd64);
		span(16'sd0, 16'sd0, 8'sd0, 8'sd0, 7'd0);
		span(16'sd0, 16'sd0, 8'sd1, 8'sd1, 7'd127);
		send_item(MODE_NONE, 10'h3ff, '1, 16'sd0, 16'sd0, 8'sd0, 8'sd0, 7'd5);
		write_reg(CFG_FLAT_COLOR, '1);
		span(16'sd5, 16'sd5, 8'sd1, 8'sd0, 7'd3);
	endtask

	task automatic test_single_layer();
		write_reg(CFG_ALL_FLAT, 64'd0);
		write_reg(CFG_LAYER_COUNT, 64'd1);
		for (int k = 0; k < 3; k++)
			for (int s = 0; s < 4; s++) begin
				load_layer(10'd0, ctrl_word(2'(k), 2'(s)));
				span(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 7'd4);
			end
	endtask

	task automatic test_layer_counts();
		write_reg(CFG_LAYER_COUNT, 64'd0);
		span(16'sd100, -16'sd100, 8'sd3, -8'sd3, 7'd5);
		write_reg(CFG_LAYER_COUNT, 64'd2);
		span(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 7'd6);
		write_reg(CFG_LAYER_COUNT, 64'd7);
		span(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 7'd4);
	endtask

	task automatic test_backpressure();
		hold_left = 400;
		for (int i = 0; i < 8; i++) random_span(0);
		// sender waits for every pixel before going on
		in_ch.valid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		random_span(0);
	endtask

	task automatic test_random(int count);
		int pick, idx;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				random_span(6);
			end else if (pick < 75) begin
				idx = $urandom_range(0, NLAYER*LAYER_WORDS - 1);
				load_layer(10'(idx), layer_word(idx));
			end else if (pick < 90) begin
				load_lut(10'($urandom_range(0, LUT_N - 1)), {$urandom, $urandom});
			end else if (pick < 95) begin
				send_item(MODE_NONE, 10'($urandom), {$urandom, $urandom}, 16'($urandom),
					16'($urandom), 8'($urandom), 8'($urandom), 7'($urandom));
			end else begin
				load_layer(10'($urandom_range(32, 1023)), {$urandom, $urandom});
			end
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_LUT;
		in_ch.addr = '0;
		in_ch.data = '0;
		in_ch.pos_x = '0;
		in_ch.pos_y = '0;
		in_ch.step_x = '0;
		in_ch.step_y = '0;
		in_ch.span_length = '0;
		out_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_flat_fill();
		test_load_tables();
		test_single_layer();
		test_layer_counts();
		test_backpressure();

		snd_idle = 22;
		rcv_idle = 72;
		write_reg(CFG_LAYER_COUNT, 64'd4);
		test_random(10);
		snd_idle = 72;
		rcv_idle = 22;
		write_reg(CFG_LAYER_COUNT, 64'd1);
		write_reg(CFG_FLAT_COLOR, {$urandom, $urandom});
		test_random(10);
		snd_idle = 0;
		rcv_idle = 0;
		write_reg(CFG_LAYER_COUNT, 64'd3);
		test_random(10);
		write_reg(CFG_ALL_FLAT, 64'd1);
		test_random(4);
		drain();
		repeat (200) @(posedge clk);

		$display("covered %0d spans and %0d loads/other items, %0d pixels checked",
			spans_sent, loads_sent, pixels_seen);
		$display("flat, linear, radial and mixed layers with all spreads, under stalls");
		if (mismatches == 0 && pixel_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d pixels missing", mismatches, pixel_q.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

	// stop a hung run
	initial begin
		#100000000;
		$display("timeout");
		$display("FAILED: results differ");
		$finish;
	end

endmodule
